>>> rtl/c2p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared types and constants of the cartesian-to-polar pixel map.
// ----------------------------------------------------------------------------
package c2p_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_CENTRE_X      = 3'd0;
    localparam logic [2:0] REG_CENTRE_Y      = 3'd1;
    localparam logic [2:0] REG_RANGE_START   = 3'd2;
    localparam logic [2:0] REG_RANGE_STEP    = 3'd3;
    localparam logic [2:0] REG_BEARING_START = 3'd4;
    localparam logic [2:0] REG_BEARING_STEP  = 3'd5;
    localparam logic [2:0] REG_TRANSPOSED    = 3'd6;

    // Saturation limits of the Q16.16 results
    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // Stage counts of the fixed parts of the two paths
    localparam int SQRT_STAGES = 32;
    localparam int RDIV_STAGES = 31;
    localparam int BDIV_STAGES = 32;

    // Flags riding along the radius divider
    typedef struct packed {
        logic mzero;  // magnitude is zero
        logic ovf;    // quotient does not fit
    } t_rad_flags;

    // Flags riding along the bearing divider
    typedef struct packed {
        logic oxzero; // horizontal offset is zero
        logic neg;    // bearing difference is negative
        logic dz;     // bearing difference is zero
        logic ovf;    // quotient magnitude does not fit 32 bits
    } t_brg_flags;

    // Arctangent of 2^-i in radians, 24 fraction bits
    function automatic logic [23:0] f_atan_q24(input int unsigned idx);
        logic [23:0] v;
        case (idx)
            0:       v = 24'd13176795;
            1:       v = 24'd7778716;
            2:       v = 24'd4110060;
            3:       v = 24'd2086331;
            4:       v = 24'd1047214;
            5:       v = 24'd524117;
            6:       v = 24'd262123;
            7:       v = 24'd131069;
            8:       v = 24'd65536;
            9:       v = 24'd32768;
            10:      v = 24'd16384;
            11:      v = 24'd8192;
            12:      v = 24'd4096;
            13:      v = 24'd2048;
            14:      v = 24'd1024;
            15:      v = 24'd512;
            16:      v = 24'd256;
            17:      v = 24'd128;
            18:      v = 24'd64;
            19:      v = 24'd32;
            20:      v = 24'd16;
            21:      v = 24'd8;
            22:      v = 24'd4;
            23:      v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/cartesian_to_polar_pixel_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_polar_pixel_map
// Maps a pixel (column, row) to a scaled radius and bearing in Q16.16.
//
//   channel   direction  contents
//   s_axis    in         tdata: column, row
//   m_axis    out        tdata: first_value, second_value
//   cfg       in         write enable, register index, write data
//
// One word enters per clock while s_axis_tready is high; each result's delay
// is set by the 32-stage square root and the 31-stage radius divider.
// The bearing path (CORDIC, 32-stage divider) is delayed to match.
// A two-entry output buffer keeps s_axis_tready registered; a stall on
// m_axis freezes the whole pipeline and loses nothing.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module cartesian_to_polar_pixel_map
    import c2p_pkg::*;
#(
    parameter int COORD_BITS    = 12,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // column [COORD_BITS-1:0], row [2*COORD_BITS-1:COORD_BITS]
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // first_value [31:0], second_value [63:32]
    output logic [63:0]                            m_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic                                   i_cfg_we,
    input  logic [2:0]                             i_cfg_idx,
    input  logic [23:0]                            i_cfg_data
);

    localparam int CB  = COORD_BITS;
    localparam int OW  = ((CB + 8 > 21) ? CB + 8 : 21) + 2;
    localparam int LAT = 3 + SQRT_STAGES + 1 + RDIV_STAGES + 1;
    localparam int BDL = LAT - 1 - (2 + CORDIC_STAGES + 2 + BDIV_STAGES);

    // Configuration registers
    logic signed [20:0] r_centre_x;
    logic signed [20:0] r_centre_y;
    logic signed [20:0] r_range_start;
    logic [23:0]        r_range_step;
    logic signed [18:0] r_bearing_start;
    logic [23:0]        r_bearing_step;
    logic               r_transposed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_x      <= '0;
            r_centre_y      <= '0;
            r_range_start   <= '0;
            r_range_step    <= 24'd65536;
            r_bearing_start <= '0;
            r_bearing_step  <= 24'd292818;
            r_transposed    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTRE_X:      r_centre_x      <= i_cfg_data[20:0];
                REG_CENTRE_Y:      r_centre_y      <= i_cfg_data[20:0];
                REG_RANGE_START:   r_range_start   <= i_cfg_data[20:0];
                REG_RANGE_STEP:    r_range_step    <= i_cfg_data;
                REG_BEARING_START: r_bearing_start <= i_cfg_data[18:0];
                REG_BEARING_STEP:  r_bearing_step  <= i_cfg_data;
                REG_TRANSPOSED:    r_transposed    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline advances while the output buffer has room
    logic r_skid_vld;
    logic en;
    assign en            = !r_skid_vld;
    assign s_axis_tready = en;

    // Valid bits travel alongside the data
    logic r_vld [LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Stage 1: offsets from the centre, with the range start also subtracted
    logic signed [OW-1:0] n_ox, n_oy, r_ox, r_oy;
    logic signed [OW-1:0] n_rs;
    always_comb begin
        n_rs = OW'(r_range_start);
        n_ox = $signed(OW'({s_axis_tdata[CB-1:0], 8'h00}))
               - n_rs - OW'(r_centre_x);
        n_oy = $signed(OW'({s_axis_tdata[2*CB-1:CB], 8'h00}))
               - n_rs - OW'(r_centre_y);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox <= n_ox;
            r_oy <= n_oy;
        end
    end

    // Stage 2: squares at full product width
    logic signed [2*OW-1:0] n_sqx, n_sqy;
    logic [2*OW-1:0] r_sqx, r_sqy;
    always_comb begin
        n_sqx = r_ox * r_ox;
        n_sqy = r_oy * r_oy;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqx <= n_sqx;
            r_sqy <= n_sqy;
        end
    end

    // Stage 3: sum of squares, pick the radicand scaling
    logic [63:0] n_sum;
    logic        n_big;
    logic [63:0] r_rad;
    logic        r_big;
    always_comb begin
        n_sum = 64'(r_sqx) + 64'(r_sqy);
        n_big = (n_sum >= 64'h0000_8000_0000_0000);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad <= n_big ? n_sum : (n_sum << 16);
            r_big <= n_big;
        end
    end

    logic [31:0] sq_root;
    logic        sq_big;

    c2p_sqrt #(
        .TW (1)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_rad),
        .i_tag  (r_big),
        .o_root (sq_root),
        .o_tag  (sq_big)
    );

    // Radius divider setup: magnitude, zero and overflow tests, leading remainder
    logic [39:0]  n_mag;
    t_rad_flags   n_rflags, r_rflags;
    logic [23:0]  r_rrem;
    logic [30:0]  r_rlow;
    always_comb begin
        n_mag          = sq_big ? {sq_root, 8'h00} : {8'h00, sq_root};
        n_rflags.mzero = (sq_root == '0);
        n_rflags.ovf   = (n_mag >= {1'b0, r_range_step, 15'h0000});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rflags <= n_rflags;
            r_rrem   <= n_mag[38:15];
            r_rlow   <= {n_mag[14:0], 16'h0000};
        end
    end

    logic [30:0] rq;
    t_rad_flags  rq_flags;

    c2p_div #(
        .QB (RDIV_STAGES),
        .DW (24),
        .TW ($bits(t_rad_flags))
    ) u_rdiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem (r_rrem),
        .i_low (r_rlow),
        .i_dvs (r_range_step),
        .i_tag (r_rflags),
        .o_quo (rq),
        .o_tag (rq_flags)
    );

    // Bearing path: CORDIC on the offsets
    logic signed [26:0] cz;
    logic               cz_oxzero;

    c2p_cordic #(
        .OW     (OW),
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_ox     (r_ox),
        .i_oy     (r_oy),
        .o_z      (cz),
        .o_oxzero (cz_oxzero)
    );

    // Round the angle to Q.16 and remove the bearing start
    logic signed [26:0] n_zr;
    logic signed [19:0] n_d, r_d;
    logic               r_d_oxz;
    always_comb begin
        n_zr = cz + 27'sd128;
        n_d  = 20'(n_zr >>> 8) - 20'(r_bearing_start);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d     <= n_d;
            r_d_oxz <= cz_oxzero;
        end
    end

    // Bearing divider setup: magnitude, sign, overflow test
    logic [19:0] n_ad;
    t_brg_flags  n_bflags, r_bflags;
    logic [23:0] r_brem;
    logic [31:0] r_blow;
    always_comb begin
        n_ad            = (r_d < 0) ? 20'(-r_d) : r_d;
        n_bflags.oxzero = r_d_oxz;
        n_bflags.neg    = (r_d < 0);
        n_bflags.dz     = (r_d == '0);
        n_bflags.ovf    = ({12'h000, n_ad} >= {r_bearing_step, 8'h00});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bflags <= n_bflags;
            r_brem   <= {12'h000, n_ad[19:8]};
            r_blow   <= {n_ad[7:0], 24'h000000};
        end
    end

    logic [31:0] bq;
    t_brg_flags  bq_flags;

    c2p_div #(
        .QB (BDIV_STAGES),
        .DW (24),
        .TW ($bits(t_brg_flags))
    ) u_bdiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem (r_brem),
        .i_low (r_blow),
        .i_dvs (r_bearing_step),
        .i_tag (r_bflags),
        .o_quo (bq),
        .o_tag (bq_flags)
    );

    // Delay the bearing to line up with the radius
    logic [31:0] r_bq_dly [BDL];
    t_brg_flags  r_bf_dly [BDL];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bq_dly[0] <= bq;
            r_bf_dly[0] <= bq_flags;
            for (int k = 1; k < BDL; k++) begin
                r_bq_dly[k] <= r_bq_dly[k-1];
                r_bf_dly[k] <= r_bf_dly[k-1];
            end
        end
    end

    // Final stage: saturate both results and order them
    logic [31:0] n_radius, n_bearing;
    logic [31:0] bqd;
    t_brg_flags  bfd;
    logic [63:0] r_fin;
    always_comb begin
        bqd = r_bq_dly[BDL-1];
        bfd = r_bf_dly[BDL-1];
        if (rq_flags.mzero)    n_radius = '0;
        else if (rq_flags.ovf) n_radius = SAT_MAX;
        else                   n_radius = {1'b0, rq};

        if (bfd.oxzero || bfd.dz) begin
            n_bearing = '0;
        end else if (bfd.ovf) begin
            n_bearing = bfd.neg ? SAT_MIN : SAT_MAX;
        end else if (bfd.neg) begin
            n_bearing = (bqd > SAT_MIN) ? SAT_MIN : 32'(-bqd);
        end else begin
            n_bearing = bqd[31] ? SAT_MAX : bqd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fin <= r_transposed ? {n_radius, n_bearing} : {n_bearing, n_radius};
        end
    end

    // Output register with one skid entry
    logic        r_out_vld;
    logic [63:0] r_out;
    logic [63:0] r_skid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (m_axis_tready) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || m_axis_tready) begin
            r_out_vld <= r_vld[LAT-1];
        end else if (r_vld[LAT-1]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (m_axis_tready) r_out <= r_skid;
        end else if (!r_out_vld || m_axis_tready) begin
            r_out <= r_fin;
        end else begin
            r_skid <= r_fin;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

endmodule

>>> rtl/c2p_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_sqrt
// Pipelined restoring square root: 64-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module c2p_sqrt
    import c2p_pkg::*;
#(
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [63:0]   i_rad,
    input  logic [TW-1:0] i_tag,
    output logic [31:0]   o_root,
    output logic [TW-1:0] o_tag
);

    logic [63:0]   r_rad  [SQRT_STAGES+1];
    logic [33:0]   r_rem  [SQRT_STAGES+1];
    logic [31:0]   r_root [SQRT_STAGES+1];
    logic [TW-1:0] r_tag  [SQRT_STAGES+1];

    // Stage zero is the module input
    always_comb begin
        r_rad[0]  = i_rad;
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_tag[0]  = i_tag;
    end

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [35:0] n_trial;
        logic [35:0] n_cmp;
        logic        n_ge;

        // Bring in two radicand bits and try the next root bit
        always_comb begin
            n_trial = {r_rem[k], r_rad[k][63:62]};
            n_cmp   = {2'b00, r_root[k], 2'b01};
            n_ge    = (n_trial >= n_cmp);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k+1]  <= {r_rad[k][61:0], 2'b00};
                r_rem[k+1]  <= n_ge ? 34'(n_trial - n_cmp) : n_trial[33:0];
                r_root[k+1] <= {r_root[k][30:0], n_ge};
                r_tag[k+1]  <= r_tag[k];
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES];
    assign o_tag  = r_tag[SQRT_STAGES];

endmodule

>>> rtl/c2p_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_div
// Pipelined restoring divider: one quotient bit per stage, one divisor input shared by all stages.
// ----------------------------------------------------------------------------
module c2p_div
    import c2p_pkg::*;
#(
    parameter int QB = 31,
    parameter int DW = 24,
    parameter int TW = 2
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,
    input  logic [QB-1:0] i_low,
    input  logic [DW-1:0] i_dvs,
    input  logic [TW-1:0] i_tag,
    output logic [QB-1:0] o_quo,
    output logic [TW-1:0] o_tag
);

    logic [DW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_low [QB+1];
    logic [QB-1:0] r_quo [QB+1];
    logic [TW-1:0] r_tag [QB+1];

    // Stage zero is the module input
    always_comb begin
        r_rem[0] = i_rem;
        r_low[0] = i_low;
        r_quo[0] = '0;
        r_tag[0] = i_tag;
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [DW:0] n_trial;
        logic        n_ge;

        // Shift in the next dividend bit and subtract where it fits
        always_comb begin
            n_trial = {r_rem[k], r_low[k][QB-1]};
            n_ge    = (n_trial >= {1'b0, i_dvs});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_ge ? DW'(n_trial - {1'b0, i_dvs}) : n_trial[DW-1:0];
                r_low[k+1] <= r_low[k] << 1;
                r_quo[k+1] <= {r_quo[k][QB-2:0], n_ge};
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    assign o_quo = r_quo[QB];
    assign o_tag = r_tag[QB];

endmodule

>>> rtl/c2p_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_cordic
// Vectoring CORDIC: folds the vector into the right half plane, then rotates
// it onto the x axis one stage per micro-rotation, summing the angle in Q.24.
// ----------------------------------------------------------------------------
module c2p_cordic
    import c2p_pkg::*;
#(
    parameter int OW     = 23,
    parameter int STAGES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [OW-1:0] i_ox,
    input  logic signed [OW-1:0] i_oy,
    output logic signed [26:0]   o_z,
    output logic                 o_oxzero
);

    localparam int CW = OW + 26;

    logic signed [CW-1:0] r_x  [STAGES+1];
    logic signed [CW-1:0] r_y  [STAGES+1];
    logic signed [26:0]   r_z  [STAGES+1];
    logic                 r_oz [STAGES+1];

    logic signed [CW-1:0] n_x0;
    logic signed [CW-1:0] n_y0;

    // Mirror into the right half plane and scale to 24 fraction bits
    always_comb begin
        n_x0 = CW'(i_ox) <<< 24;
        n_y0 = CW'(i_oy) <<< 24;
        if (i_ox < 0) begin
            n_x0 = -n_x0;
            n_y0 = -n_y0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= n_x0;
            r_y[0]  <= n_y0;
            r_z[0]  <= '0;
            r_oz[0] <= (i_ox == '0);
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic signed [CW-1:0] n_xs;
        logic signed [CW-1:0] n_ys;
        logic signed [26:0]   n_at;

        always_comb begin
            n_xs = r_x[k] >>> k;
            n_ys = r_y[k] >>> k;
            n_at = $signed({3'b000, f_atan_q24(k)});
        end

        // Rotate toward the x axis by the sign of y
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[k] > 0) begin
                    r_x[k+1] <= r_x[k] + n_ys;
                    r_y[k+1] <= r_y[k] - n_xs;
                    r_z[k+1] <= r_z[k] + n_at;
                end else begin
                    r_x[k+1] <= r_x[k] - n_ys;
                    r_y[k+1] <= r_y[k] + n_xs;
                    r_z[k+1] <= r_z[k] - n_at;
                end
                r_oz[k+1] <= r_oz[k];
            end
        end
    end

    assign o_z      = r_z[STAGES];
    assign o_oxzero = r_oz[STAGES];

endmodule
